@@ hdl/ldu_pkg.sv @@
// Package for the LDU matrix-vector residual block: widths, modes, states and
// the fixed-point helpers. No dependencies.
`default_nettype none
package ldu_pkg;
  localparam int CellCount    = 1024;
  localparam int IndexWidth   = 10;
  localparam int ValueWidth   = 32;
  localparam int FractionBits = 16;
  localparam int AccWidth     = 48;
  localparam int ProdWidth    = 2 * ValueWidth;

  typedef logic [IndexWidth-1:0] index_t;
  typedef logic signed [ValueWidth-1:0] value_t;
  typedef logic signed [AccWidth-1:0] acc_t;
  typedef logic signed [ProdWidth-1:0] prod_t;

  typedef enum logic [1:0] {
    ModeLoad  = 2'd0,
    ModeFace  = 2'd1,
    ModeRead  = 2'd2,
    ModeSpare = 2'd3
  } mode_e;

  typedef enum logic [2:0] {
    StIdle,
    StFetch,
    StMul,
    StOwner,
    StNeigh,
    StRead
  } state_e;

  localparam acc_t AccMax = {1'b0, {(AccWidth-1){1'b1}}};
  localparam acc_t AccMin = {1'b1, {(AccWidth-1){1'b0}}};

  // Arithmetic shift of an exact product (floor) then clamp to the accumulator
  function automatic logic [AccWidth:0] scale_sat(input prod_t p);
    logic signed [ProdWidth-1:0] s;
    logic ovf;
    s = p >>> FractionBits;
    ovf = (s > $signed({{(ProdWidth-AccWidth){1'b0}}, AccMax})) ||
          (s < $signed({{(ProdWidth-AccWidth){1'b1}}, AccMin}));
    if (s > $signed({{(ProdWidth-AccWidth){1'b0}}, AccMax}))
      return {1'b1, AccMax};
    if (ovf)
      return {1'b1, AccMin};
    return {1'b0, s[AccWidth-1:0]};
  endfunction

  // Saturating 48-bit add, flag in the top bit
  function automatic logic [AccWidth:0] add_sat(input acc_t a, input acc_t b);
    logic signed [AccWidth:0] s;
    s = {a[AccWidth-1], a} + {b[AccWidth-1], b};
    if (s[AccWidth] != s[AccWidth-1])
      return {1'b1, (s[AccWidth] ? AccMin : AccMax)};
    return {1'b0, s[AccWidth-1:0]};
  endfunction

  // Saturating 48-bit subtract, flag in the top bit
  function automatic logic [AccWidth:0] sub_sat(input acc_t a, input acc_t b);
    logic signed [AccWidth:0] s;
    s = {a[AccWidth-1], a} - {b[AccWidth-1], b};
    if (s[AccWidth] != s[AccWidth-1])
      return {1'b1, (s[AccWidth] ? AccMin : AccMax)};
    return {1'b0, s[AccWidth-1:0]};
  endfunction
endpackage
`default_nettype wire

@@ hdl/ldu_store.sv @@
// Cell store: unknown, source, product and overflow mark memories.
// Depends on ldu_pkg. One write and one registered read per memory per cycle.
`default_nettype none
module ldu_store (
  input  wire logic            clk_i,
  input  wire logic            x_we_i,
  input  wire ldu_pkg::index_t x_waddr_i,
  input  wire ldu_pkg::value_t x_wdata_i,
  input  wire ldu_pkg::index_t x_raddr_i,
  output ldu_pkg::value_t      x_rdata_o,
  input  wire logic            p_we_i,
  input  wire ldu_pkg::index_t p_waddr_i,
  input  wire ldu_pkg::value_t s_wdata_i,
  input  wire logic            s_we_i,
  input  wire ldu_pkg::acc_t   p_wdata_i,
  input  wire logic            o_wdata_i,
  input  wire ldu_pkg::index_t p_raddr_i,
  output ldu_pkg::acc_t        p_rdata_o,
  output ldu_pkg::value_t      s_rdata_o,
  output logic                 o_rdata_o
);
  import ldu_pkg::*;
  value_t x_mem [CellCount];
  value_t s_mem [CellCount];
  acc_t   p_mem [CellCount];
  logic   o_mem [CellCount];

  // Unknowns
  always_ff @(posedge clk_i) begin
    if (x_we_i) x_mem[x_waddr_i] <= x_wdata_i;
    x_rdata_o <= x_mem[x_raddr_i];
  end

  // Sources
  always_ff @(posedge clk_i) begin
    if (s_we_i) s_mem[p_waddr_i] <= s_wdata_i;
    s_rdata_o <= s_mem[p_raddr_i];
  end

  // Products and overflow marks
  always_ff @(posedge clk_i) begin
    if (p_we_i) begin
      p_mem[p_waddr_i] <= p_wdata_i;
      o_mem[p_waddr_i] <= o_wdata_i;
    end
    p_rdata_o <= p_mem[p_raddr_i];
    o_rdata_o <= o_mem[p_raddr_i];
  end
endmodule
`default_nettype wire

@@ hdl/ldu_matrix_vector_residual.sv @@
// Top level of the LDU matrix-vector residual block with its sequencer.
// Depends on ldu_pkg and ldu_store.
`default_nettype none
// One item at a time: busy_o rises on the edge that takes start_i, except for
// mode 3 items and faces without a neighbour, which are taken while busy_o stays
// low. A load multiplies, scales and writes all stores; a read strobes its
// result on result_valid_o; a face does a fetch of both unknowns, then two
// read-modify-write passes over the single product port.
// Results cannot be stalled. Memory contents are undefined after reset.
module ldu_matrix_vector_residual (
  input  wire logic         clk_i,
  input  wire logic         rst_ni,
  input  wire logic         start_i,
  output logic              busy_o,
  input  wire logic [1:0]   mode_i,
  input  wire logic [9:0]   cell_index_i,
  input  wire logic [9:0]   neighbour_index_i,
  input  wire logic         has_neighbour_i,
  input  wire logic         owner_owned_i,
  input  wire logic         neighbour_owned_i,
  input  wire logic [31:0]  diag_coeff_i,
  input  wire logic [31:0]  source_term_i,
  input  wire logic [31:0]  unknown_value_i,
  input  wire logic [31:0]  upper_coeff_i,
  input  wire logic [31:0]  lower_coeff_i,
  output logic              result_valid_o,
  output logic [9:0]        result_cell_o,
  output logic [47:0]       product_value_o,
  output logic [47:0]       residual_value_o,
  output logic              saturated_o
);
  import ldu_pkg::*;

  state_e state_q, state_d;
  logic [2:0] step_q, step_d;
  mode_e  mode_q;
  index_t c_q, n_q;
  logic   oo_q, no_q;
  value_t a_q, b_q, x_q, s_q, xo_q, xn_q;
  prod_t  m_q, m_d;
  logic   [AccWidth:0] sc_q;

  logic   x_we, p_we, s_we, o_wd;
  index_t x_ra, p_ra, p_wa;
  value_t x_rd, s_rd;
  acc_t   p_rd, p_wd;
  logic   o_rd;
  logic [AccWidth:0] acc_r, res_r;
  logic   accept;

  assign accept = start_i && !busy_o;
  assign busy_o = (state_q != StIdle);

  ldu_store u_store (
    .clk_i, .x_we_i(x_we), .x_waddr_i(c_q), .x_wdata_i(x_q), .x_raddr_i(x_ra),
    .x_rdata_o(x_rd), .p_we_i(p_we), .p_waddr_i(p_wa), .s_wdata_i(s_q),
    .s_we_i(s_we), .p_wdata_i(p_wd), .o_wdata_i(o_wd), .p_raddr_i(p_ra),
    .p_rdata_o(p_rd), .s_rdata_o(s_rd), .o_rdata_o(o_rd)
  );

  // Latch the item
  always_ff @(posedge clk_i) begin
    if (accept) begin
      mode_q <= mode_e'(mode_i);
      c_q <= cell_index_i; n_q <= neighbour_index_i;
      oo_q <= owner_owned_i; no_q <= neighbour_owned_i;
      s_q <= source_term_i; x_q <= unknown_value_i;
      a_q <= (mode_i == ModeLoad) ? diag_coeff_i : upper_coeff_i;
      b_q <= lower_coeff_i;
    end
    if (state_q == StFetch && step_q == 3'd1) xo_q <= x_rd;
    if (state_q == StFetch && step_q == 3'd2) xn_q <= x_rd;
    m_q  <= m_d;
    sc_q <= scale_sat(m_q);
  end

  // Sequencer state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle; step_q <= '0;
    end else begin
      state_q <= state_d; step_q <= step_d;
    end
  end

  assign acc_r = add_sat(p_rd, sc_q[AccWidth-1:0]);
  assign res_r = sub_sat({{(AccWidth-ValueWidth){s_rd[ValueWidth-1]}}, s_rd}, p_rd);

  // Next state and memory control
  always_comb begin
    state_d = state_q; step_d = step_q + 3'd1;
    x_we = 1'b0; s_we = 1'b0; p_we = 1'b0;
    x_ra = c_q; p_ra = c_q; p_wa = c_q; p_wd = sc_q[AccWidth-1:0];
    o_wd = sc_q[AccWidth]; m_d = m_q;
    result_valid_o = 1'b0;
    case (state_q)
      StIdle: begin
        step_d = '0;
        if (accept) begin
          case (mode_i)
            ModeLoad: state_d = StMul;
            ModeFace: state_d = has_neighbour_i ? StFetch : StIdle;
            ModeRead: state_d = StRead;
            default:  state_d = StIdle;
          endcase
        end
      end
      StMul: begin
        // load: multiply, scale, then write all stores
        m_d = $signed(a_q) * $signed(x_q);
        if (step_q == 3'd2) begin
          x_we = 1'b1; s_we = 1'b1; p_we = 1'b1;
          state_d = StIdle;
        end
      end
      StFetch: begin
        // read owner unknown, then neighbour unknown
        x_ra = (step_q == 3'd0) ? c_q : n_q;
        if (step_q == 3'd2) begin
          state_d = StOwner; step_d = '0;
        end
      end
      StOwner: begin
        // multiply upper by neighbour unknown, read and update owner product
        m_d = $signed(a_q) * $signed(xn_q);
        p_ra = c_q;
        if (step_q == 3'd2) begin
          p_wa = c_q; p_wd = acc_r[AccWidth-1:0];
          o_wd = o_rd | acc_r[AccWidth] | sc_q[AccWidth];
          p_we = oo_q;
          state_d = StNeigh; step_d = '0;
        end
      end
      StNeigh: begin
        // owner write lands before this read, so no forwarding needed
        m_d = $signed(b_q) * $signed(xo_q);
        p_ra = n_q;
        if (step_q == 3'd2) begin
          p_wa = n_q; p_wd = acc_r[AccWidth-1:0];
          o_wd = o_rd | acc_r[AccWidth] | sc_q[AccWidth];
          p_we = no_q;
          state_d = StIdle;
        end
      end
      StRead: begin
        if (step_q == 3'd1) begin
          result_valid_o = 1'b1;
          state_d = StIdle;
        end
      end
      default: state_d = StIdle;
    endcase
  end

  assign result_cell_o    = c_q;
  assign product_value_o  = p_rd;
  assign residual_value_o = res_r[AccWidth-1:0];
  assign saturated_o      = o_rd | res_r[AccWidth];

  // Results only come from a read
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o |-> (state_q == StRead && mode_q == ModeRead))
    else $error("result outside a read");
  // Start is taken only while idle
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start_i && !busy_o) |=> busy_o || $past(mode_i) == ModeSpare ||
      ($past(mode_i) == ModeFace && !$past(has_neighbour_i)))
    else $error("item dropped");
  // No product write during a read
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == StRead) |-> !p_we)
    else $error("write during read");
endmodule
`default_nettype wire

@@ sim/tb_ldu_matrix_vector_residual.sv @@
// Testbench for the LDU matrix-vector residual block: loads cells, applies faces
// and reads cells, checking every read against an in-bench model of the block.
// Depends on ldu_pkg and the block's RTL.
`timescale 1ns / 100ps
module tb_ldu_matrix_vector_residual;
  import ldu_pkg::*;

  localparam longint AccHi = 64'sd140737488355327;
  localparam longint AccLo = -64'sd140737488355328;

  logic        clk_i;
  logic        rst_ni;
  logic        start_i;
  logic        busy_o;
  logic [1:0]  mode_i;
  logic [9:0]  cell_index_i;
  logic [9:0]  neighbour_index_i;
  logic        has_neighbour_i;
  logic        owner_owned_i;
  logic        neighbour_owned_i;
  logic [31:0] diag_coeff_i;
  logic [31:0] source_term_i;
  logic [31:0] unknown_value_i;
  logic [31:0] upper_coeff_i;
  logic [31:0] lower_coeff_i;
  logic        result_valid_o;
  logic [9:0]  result_cell_o;
  logic [47:0] product_value_o;
  logic [47:0] residual_value_o;
  logic        saturated_o;

  typedef struct packed {
    logic [9:0]  cell_id;
    logic [47:0] product;
    logic [47:0] residual;
    logic        sat;
  } cell_report_t;

  ldu_matrix_vector_residual uut (.*);

  // Model state
  longint       unknown_mem [CellCount];
  longint       source_mem  [CellCount];
  longint       product_mem [CellCount];
  bit           ovf_mem     [CellCount];
  bit           loaded      [CellCount];
  cell_report_t pending_reports [$];
  int           fail_count;

  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  // Clamp to the 48-bit accumulator range, flagging overflow
  function automatic longint clamp48(input longint v, inout bit sat);
    if (v > AccHi) begin
      sat = 1'b1;
      return AccHi;
    end
    if (v < AccLo) begin
      sat = 1'b1;
      return AccLo;
    end
    return v;
  endfunction

  // Exact 32x32 product, floor shift, saturate to 48 bits
  function automatic longint scaled_product(input longint a, input longint b,
                                            inout bit sat);
    logic signed [127:0] p;
    p = 128'(a) * 128'(b);
    p = p >>> FractionBits;
    if (p > 128'(AccHi)) begin
      sat = 1'b1;
      return AccHi;
    end
    if (p < 128'(AccLo)) begin
      sat = 1'b1;
      return AccLo;
    end
    return longint'(p);
  endfunction

  // Update the model for one accepted item and queue any report it causes
  task automatic predict_item(input logic [1:0] m, input logic [9:0] c,
                              input logic [9:0] n, input logic hn, input logic oo,
                              input logic no, input logic [31:0] d,
                              input logic [31:0] s, input logic [31:0] x,
                              input logic [31:0] u, input logic [31:0] l);
    bit sat;
    longint xo, xn, p, r;
    cell_report_t rep;
    sat = 1'b0;
    case (m)
      ModeLoad: begin
        unknown_mem[c] = longint'($signed(x));
        source_mem[c] = longint'($signed(s));
        product_mem[c] = scaled_product(longint'($signed(d)), unknown_mem[c], sat);
        ovf_mem[c] = sat;
        loaded[c] = 1'b1;
      end
      ModeFace: begin
        if (hn) begin
          xo = unknown_mem[c];
          xn = unknown_mem[n];
          if (oo) begin
            sat = 1'b0;
            p = scaled_product(longint'($signed(u)), xn, sat);
            product_mem[c] = clamp48(product_mem[c] + p, sat);
            if (sat) ovf_mem[c] = 1'b1;
          end
          if (no) begin
            sat = 1'b0;
            p = scaled_product(longint'($signed(l)), xo, sat);
            product_mem[n] = clamp48(product_mem[n] + p, sat);
            if (sat) ovf_mem[n] = 1'b1;
          end
        end
      end
      ModeRead: begin
        p = product_mem[c];
        sat = ovf_mem[c];
        r = clamp48(source_mem[c] - p, sat);
        rep.cell_id = c;
        rep.product = p[47:0];
        rep.residual = r[47:0];
        rep.sat = sat;
        pending_reports = {pending_reports, rep};
      end
      default: ;
    endcase
  endtask

  // Drop start for a random gap, send one item, then wait until busy_o is low;
  // start stays high afterwards so a gap of zero gives back-to-back items
  task automatic send_item(input logic [1:0] m, input logic [9:0] c,
                           input logic [9:0] n, input logic hn, input logic oo,
                           input logic no, input logic [31:0] d,
                           input logic [31:0] s, input logic [31:0] x,
                           input logic [31:0] u, input logic [31:0] l,
                           input int gap);
    if (gap > 0) begin
      start_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    start_i <= 1'b1;
    mode_i <= m;
    cell_index_i <= c;
    neighbour_index_i <= n;
    has_neighbour_i <= hn;
    owner_owned_i <= oo;
    neighbour_owned_i <= no;
    diag_coeff_i <= d;
    source_term_i <= s;
    unknown_value_i <= x;
    upper_coeff_i <= u;
    lower_coeff_i <= l;
    @(posedge clk_i);
    while (busy_o) @(posedge clk_i);
    predict_item(m, c, n, hn, oo, no, d, s, x, u, l);
  endtask

  function automatic int draw_gap();
    return $urandom_range(0, 4);
  endfunction

  // Pick a loaded cell between lo and hi, or lo if none of them is loaded yet
  function automatic logic [9:0] pick_loaded(input logic [9:0] lo, input logic [9:0] hi);
    logic [9:0] c;
    for (int k = 0; k < 64; k++) begin
      c = 10'($urandom_range(lo, hi));
      if (loaded[c]) return c;
    end
    for (int k = lo; k <= hi; k++) if (loaded[k]) return k[9:0];
    return lo;
  endfunction

  // Check each result against the oldest expected report
  always @(posedge clk_i) begin
    cell_report_t want;
    if (rst_ni && result_valid_o) begin
      if (pending_reports.size() == 0) begin
        $error("unexpected result for cell %0d", result_cell_o);
        fail_count++;
      end else begin
        want = pending_reports.pop_front();
        if (result_cell_o !== want.cell_id) begin
          $error("result_cell: expected %0d, got %0d", want.cell_id, result_cell_o);
          fail_count++;
        end
        if (product_value_o !== want.product) begin
          $error("product_value: expected %h, got %h", want.product, product_value_o);
          fail_count++;
        end
        if (residual_value_o !== want.residual) begin
          $error("residual_value: expected %h, got %h", want.residual, residual_value_o);
          fail_count++;
        end
        if (saturated_o !== want.sat) begin
          $error("saturated: expected %0b, got %0b", want.sat, saturated_o);
          fail_count++;
        end
      end
    end
  end

  // Directed: extremes of values and indices, every mode, boundary and unowned faces
  task automatic test_directed();
    send_item(ModeLoad, 10'd0, 0, 0, 0, 0, 32'h7fffffff, 32'h80000000, 32'h7fffffff, 0, 0, 0);
    send_item(ModeLoad, 10'd1023, 0, 0, 0, 0, 32'h80000000, 32'h7fffffff, 32'h80000000,
              0, 0, 1);
    send_item(ModeLoad, 10'd1, 0, 0, 0, 0, 32'h00010000, 32'h00020000, 32'hffff0001, 0, 0, 0);
    send_item(ModeLoad, 10'd2, 0, 0, 0, 0, 32'hffffffff, 32'h00000001, 32'h00000001, 0, 0, 2);
    send_item(ModeRead, 10'd0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0);
    send_item(ModeRead, 10'd1023, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0);
    send_item(ModeRead, 10'd2, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0);
    // Faces with extreme coefficients, then unowned, boundary and self faces
    send_item(ModeFace, 10'd0, 10'd1023, 1, 1, 1, 0, 0, 0, 32'h7fffffff, 32'h80000000, 0);
    send_item(ModeFace, 10'd1, 10'd2, 1, 1, 0, 0, 0, 0, 32'h00010000, 32'h7fffffff, 1);
    send_item(ModeFace, 10'd2, 10'd1, 1, 0, 1, 0, 0, 0, 32'hffffffff, 32'hffff0000, 0);
    send_item(ModeFace, 10'd1, 10'd2, 0, 1, 1, 0, 0, 0, 32'h7fffffff, 32'h7fffffff, 3);
    send_item(ModeFace, 10'd1, 10'd1, 1, 1, 1, 0, 0, 0, 32'h00020000, 32'h00030000, 0);
    send_item(ModeSpare, 10'd1, 10'd2, 1, 1, 1, 32'hffffffff, 32'hffffffff, 32'hffffffff,
              32'hffffffff, 32'hffffffff, 0);
    for (int k = 0; k < 3; k++) send_item(ModeRead, k[9:0], 0, 0, 0, 0, 0, 0, 0, 0, 0, 0);
    send_item(ModeRead, 10'd1023, 10'h3ff, 1, 1, 1, 0, 0, 0, 0, 0, 0);
  endtask

  // Pause the sender until every expected report has arrived
  task automatic test_drain_pause();
    start_i <= 1'b0;
    while (pending_reports.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  // Random: load a small window of cells, apply faces and reads within it mixed with mode 3 items, read it back
  task automatic test_random_sweeps();
    int sent;
    logic [9:0] base, span, c, n;
    int r;
    sent = 0;
    while (sent < 1000) begin
      base = (($urandom_range(0, 5) == 0) ? 10'd1008 : 10'($urandom_range(0, 1000)));
      span = 10'($urandom_range(2, 15));
      for (int k = 0; k <= span; k++) begin
        send_item(ModeLoad, base + k[9:0], 10'($urandom), 1'($urandom), 1'($urandom),
                  1'($urandom), $urandom, $urandom,
                  ($urandom_range(0, 3) == 0) ? $urandom : 32'($signed($urandom_range(0, 1 << 20)) - (1 << 19)),
                  $urandom, $urandom, draw_gap());
        sent++;
      end
      repeat ($urandom_range(span, 3 * span)) begin
        r = $urandom_range(0, 9);
        c = pick_loaded(base, base + span);
        n = pick_loaded(base, base + span);
        if (r < 6)
          send_item(ModeFace, c, n, 1'(r != 0), 1'($urandom_range(0, 5) != 0),
                    1'($urandom_range(0, 5) != 0), $urandom, $urandom, $urandom,
                    (r < 3) ? $urandom : 32'($signed($urandom_range(0, 1 << 18)) - (1 << 17)),
                    (r < 3) ? $urandom : 32'($signed($urandom_range(0, 1 << 18)) - (1 << 17)),
                    draw_gap());
        else if (r < 9)
          send_item(ModeRead, c, 10'($urandom), 1'($urandom), 1'($urandom), 1'($urandom),
                    $urandom, $urandom, $urandom, $urandom, $urandom, draw_gap());
        else
          send_item(ModeSpare, 10'($urandom), 10'($urandom), 1'($urandom), 1'($urandom),
                    1'($urandom), $urandom, $urandom, $urandom, $urandom, $urandom,
                    draw_gap());
        sent++;
      end
      for (int k = 0; k <= span; k++) begin
        send_item(ModeRead, base + k[9:0], 0, 0, 0, 0, 0, 0, 0, 0, 0, draw_gap());
        sent++;
      end
    end
  endtask

  initial begin
    fail_count = 0;
    for (int k = 0; k < CellCount; k++) begin
      unknown_mem[k] = 0;
      source_mem[k] = 0;
      product_mem[k] = 0;
      ovf_mem[k] = 1'b0;
      loaded[k] = 1'b0;
    end
    rst_ni = 1'b0;
    start_i = 1'b0;
    mode_i = ModeLoad;
    cell_index_i = '0;
    neighbour_index_i = '0;
    has_neighbour_i = 1'b0;
    owner_owned_i = 1'b0;
    neighbour_owned_i = 1'b0;
    diag_coeff_i = '0;
    source_term_i = '0;
    unknown_value_i = '0;
    upper_coeff_i = '0;
    lower_coeff_i = '0;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed();
    test_drain_pause();
    test_random_sweeps();
    start_i <= 1'b0;
    while (pending_reports.size() != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);
    if (fail_count == 0 && pending_reports.size() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

  // Guard against a hang
  initial begin
    #2000000;
    $display("TEST FAILED");
    $finish;
  end
endmodule

@@ sim.f @@
hdl/ldu_pkg.sv
hdl/ldu_store.sv
hdl/ldu_matrix_vector_residual.sv
sim/tb_ldu_matrix_vector_residual.sv
